@@ sv/lsbb_pkg.sv @@
`default_nettype none
package lsbb_pkg;
    localparam int unsigned PixW = 24;
    localparam int unsigned ChanW = 8;
    localparam int unsigned AmtW = 8;
    localparam logic [1:0] ModeGauss = 2'd1;

    typedef struct packed {
        logic wr_px;       // store incoming pixel, position++, pending++
        logic pass_in;     // load output with incoming pixel
        logic start_res;   // begin accumulating result for oldest pending
        logic tap_step;    // accumulate one tap
        logic finish;      // divide/blend done, load output
        logic clr_frame;   // position and pending to 0
    } t_cmd;

    typedef struct packed {
        logic over_max;    // position >= MAX_PIXELS
        logic need_res;    // a result is due under the flush rule
        logic taps_done;
        logic div_done;
        logic last_pend;   // pending == 1
    } t_sts;
endpackage
`default_nettype wire

@@ sv/led_strip_blur_blend.sv @@
`default_nettype none
// LED strip blur and blend. One RGB pixel per input transaction; results come
// out delayed by the blur reach (R box, 2R gaussian) and end_of_strip flushes
// the rest, so one input can release up to 2R+1 results. Each accepted pixel
// is written to the window and then checked for a due result. Each result
// accumulates one window tap at a time (2R+1 box, 5 gaussian), runs a
// bit-serial divider per channel, waits in the output state for any output
// stall, and returns to the check.
// Pixels past MAX_PIXELS pass straight to the output without blurring.
module led_strip_blur_blend #(
    parameter int unsigned MAX_PIXELS = 512,
    parameter int unsigned MAX_RADIUS = 5
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire logic [7:0] i_pixel_red,
    input  wire logic [7:0] i_pixel_green,
    input  wire logic [7:0] i_pixel_blue,
    input  wire logic       i_end_of_strip,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output logic [7:0]      o_out_red,
    output logic [7:0]      o_out_green,
    output logic [7:0]      o_out_blue,
    output logic            o_frame_done
);
    import lsbb_pkg::*;

    localparam logic [1:0] RegEnable = 2'd0;
    localparam logic [1:0] RegMode = 2'd1;
    localparam logic [1:0] RegRadius = 2'd2;
    localparam logic [1:0] RegAmount = 2'd3;

    logic r_enable;
    logic [1:0] r_mode;
    logic [2:0] r_radius;
    logic [7:0] r_amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
            r_mode <= 2'd0;
            r_radius <= 3'd1;
            r_amount <= 8'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                RegEnable: r_enable <= i_cfg_data[0];
                RegMode: r_mode <= i_cfg_data[1:0];
                RegRadius: r_radius <= i_cfg_data[2:0];
                RegAmount: r_amount <= i_cfg_data;
                default: ;
            endcase
        end
    end

    t_cmd cmd;
    t_sts sts;
    logic [PixW-1:0] out_px;

    lsbb_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_eos(i_end_of_strip),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_done(o_frame_done), .i_sts(sts), .o_cmd(cmd)
    );

    lsbb_dp #(.MAX_PIXELS(MAX_PIXELS), .MAX_RADIUS(MAX_RADIUS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_sts(sts),
        .i_eos(i_end_of_strip),
        .i_px({i_pixel_red, i_pixel_green, i_pixel_blue}),
        .i_enable(r_enable), .i_mode(r_mode), .i_radius(r_radius),
        .i_amount(r_amount), .o_px(out_px)
    );

    assign o_out_red = out_px[23:16];
    assign o_out_green = out_px[15:8];
    assign o_out_blue = out_px[7:0];
endmodule
`default_nettype wire

@@ sv/lsbb_ctrl.sv @@
`default_nettype none
module lsbb_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire logic          i_eos,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic               o_done,
    input  wire lsbb_pkg::t_sts i_sts,
    output lsbb_pkg::t_cmd     o_cmd
);
    import lsbb_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_CHECK, S_TAPS, S_DIV, S_OUT} t_state;
    t_state r_state, n_state;
    logic r_eos, n_eos;
    logic r_out_valid, n_out_valid;
    logic r_done, n_done;
    logic r_pass, n_pass;

    assign o_in_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_done = r_done;

    always_comb begin
        n_state = r_state;
        n_eos = r_eos;
        n_out_valid = r_out_valid;
        n_done = r_done;
        n_pass = r_pass;
        o_cmd = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    n_eos = i_eos;
                    if (i_sts.over_max) begin
                        o_cmd.pass_in = 1'b1;
                        n_out_valid = 1'b1;
                        n_done = i_eos;
                        n_pass = 1'b1;
                        n_state = S_OUT;
                    end else begin
                        o_cmd.wr_px = 1'b1;
                        n_pass = 1'b0;
                        n_state = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                if (i_sts.need_res) begin
                    o_cmd.start_res = 1'b1;
                    n_done = r_eos && i_sts.last_pend;
                    n_state = S_TAPS;
                end else begin
                    o_cmd.clr_frame = r_eos;
                    n_state = S_IDLE;
                end
            end
            S_TAPS: begin
                o_cmd.tap_step = 1'b1;
                if (i_sts.taps_done) n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_done) begin
                    o_cmd.finish = 1'b1;
                    n_out_valid = 1'b1;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (r_pass) begin
                        o_cmd.clr_frame = r_eos;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_CHECK;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eos <= 1'b0;
            r_out_valid <= 1'b0;
            r_done <= 1'b0;
            r_pass <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eos <= n_eos;
            r_out_valid <= n_out_valid;
            r_done <= n_done;
            r_pass <= n_pass;
        end
    end
endmodule
`default_nettype wire

@@ sv/lsbb_dp.sv @@
`default_nettype none
module lsbb_dp #(
    parameter int unsigned MAX_PIXELS = 512,
    parameter int unsigned MAX_RADIUS = 5
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire lsbb_pkg::t_cmd           i_cmd,
    output lsbb_pkg::t_sts                o_sts,
    input  wire logic                     i_eos,
    input  wire logic [lsbb_pkg::PixW-1:0] i_px,
    input  wire logic                     i_enable,
    input  wire logic [1:0]               i_mode,
    input  wire logic [2:0]               i_radius,
    input  wire logic [lsbb_pkg::AmtW-1:0] i_amount,
    output logic [lsbb_pkg::PixW-1:0]     o_px
);
    import lsbb_pkg::*;

    localparam int unsigned Depth = 4 * MAX_RADIUS + 1;
    localparam int unsigned IdxW = $clog2(Depth);
    localparam int unsigned PosW = $clog2(MAX_PIXELS + 1);
    localparam int unsigned PendW = $clog2(2 * MAX_RADIUS + 2);
    localparam int unsigned OffW = $clog2(4 * MAX_RADIUS + 1) + 2;
    localparam int unsigned SumW = ChanW + 4;
    localparam int unsigned TotW = 5;
    localparam int unsigned TapW = 4;

    logic [PixW-1:0] r_win [Depth];
    logic [PosW-1:0] r_pos;
    logic [PendW-1:0] r_pend;
    logic [IdxW-1:0] r_wptr;
    logic r_eos;

    logic [2:0] eff_r;
    logic active, gauss;
    logic [PendW-1:0] reach;
    logic flush;

    always_comb begin
        eff_r = i_radius;
        if (eff_r == 3'd0) eff_r = 3'd1;
        if (32'(eff_r) > MAX_RADIUS) eff_r = 3'(MAX_RADIUS);
        active = i_enable && (i_amount != '0);
        gauss = (i_mode == ModeGauss);
        if (!active) reach = '0;
        else if (gauss) reach = PendW'({eff_r, 1'b0});
        else reach = PendW'(eff_r);
        flush = r_eos || (32'(r_pos) >= MAX_PIXELS);
    end

    // result computation
    logic [PosW-1:0] r_e;
    logic [PixW-1:0] r_orig;
    logic [TapW-1:0] r_tap;
    logic [SumW-1:0] r_s [3];
    logic [TotW-1:0] r_tot;
    logic [TapW-1:0] ntaps;
    assign ntaps = gauss ? TapW'(5) : TapW'({eff_r, 1'b1});

    logic signed [OffW+PosW:0] off, idx;
    logic [2:0] wgt;
    logic in_rng;
    logic [IdxW-1:0] ridx;
    logic [IdxW-1:0] oidx;
    logic signed [IdxW+1:0] rsum;
    logic signed [IdxW+1:0] osum;

    // window slots are addressed relative to the write pointer
    always_comb begin
        if (gauss) begin
            off = (signed'({1'b0, r_tap}) - 5'sd2) * signed'({1'b0, eff_r});
            case (r_tap)
                4'd0, 4'd4: wgt = 3'd1;
                4'd1, 4'd3: wgt = 3'd4;
                default: wgt = 3'd6;
            endcase
        end else begin
            off = signed'({1'b0, r_tap}) - signed'({1'b0, eff_r});
            wgt = 3'd1;
        end
        idx = signed'({1'b0, r_e}) + off;
        in_rng = (idx >= 0) && (idx < signed'({1'b0, r_pos}));
        rsum = signed'((IdxW+2)'(r_wptr))
             + (IdxW+2)'(idx - signed'({1'b0, r_pos}));
        if (rsum < 0) rsum = rsum + (IdxW+2)'(Depth);
        ridx = IdxW'(rsum);
        osum = signed'((IdxW+2)'(r_wptr)) - signed'((IdxW+2)'(r_pend));
        if (osum < 0) osum = osum + (IdxW+2)'(Depth);
        oidx = IdxW'(osum);
    end

    logic [PixW-1:0] tap_px;
    assign tap_px = r_win[ridx];

    // restoring divider, one quotient bit per cycle
    logic [3:0] r_dcnt;
    logic [SumW-1:0] r_q [3];
    logic [SumW-1:0] r_rem [3];
    logic r_div_busy;

    logic [PixW-1:0] blend;
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            logic [ChanW-1:0] a, b;
            logic [17:0] t;
            a = r_orig[16-8*c +: 8];
            b = r_q[c][ChanW-1:0];
            t = 18'({a, 8'd0}) + 18'(b) + 18'(b) * 18'(i_amount) - 18'(a) * 18'(i_amount);
            blend[16-8*c +: 8] = t[15:8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_px) begin
            r_win[r_wptr] <= i_px;
            r_eos <= i_eos;
        end
        if (i_cmd.pass_in) o_px <= i_px;
        if (i_cmd.finish) o_px <= active ? blend : r_orig;
        if (i_cmd.start_res) begin
            r_e <= r_pos - PosW'(r_pend);
            r_orig <= r_win[oidx];
            r_tap <= '0;
            r_tot <= '0;
            for (int c = 0; c < 3; c++) r_s[c] <= '0;
        end
        if (i_cmd.tap_step) begin
            r_tap <= r_tap + 1'b1;
            if (in_rng) begin
                r_tot <= r_tot + TotW'(wgt);
                for (int c = 0; c < 3; c++)
                    r_s[c] <= r_s[c] + SumW'(tap_px[16-8*c +: 8]) * SumW'(wgt);
            end
            if (o_sts.taps_done) begin
                r_dcnt <= 4'(SumW);
                for (int c = 0; c < 3; c++) r_rem[c] <= '0;
            end
        end
        if (r_div_busy && r_dcnt != 0) begin
            r_dcnt <= r_dcnt - 1'b1;
            for (int c = 0; c < 3; c++) begin
                logic [SumW:0] tr;
                logic [TotW-1:0] d;
                d = (r_tot == 0) ? TotW'(1) : r_tot;
                tr = {r_rem[c], r_s[c][SumW-1]};
                if (tr >= (SumW+1)'(d)) begin
                    r_rem[c] <= SumW'(tr - (SumW+1)'(d));
                    r_q[c] <= {r_q[c][SumW-2:0], 1'b1};
                end else begin
                    r_rem[c] <= SumW'(tr);
                    r_q[c] <= {r_q[c][SumW-2:0], 1'b0};
                end
                r_s[c] <= {r_s[c][SumW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_pend <= '0;
            r_wptr <= '0;
            r_div_busy <= 1'b0;
        end else begin
            if (i_cmd.tap_step && o_sts.taps_done) r_div_busy <= 1'b1;
            if (i_cmd.finish) r_div_busy <= 1'b0;
            if (i_cmd.wr_px) begin
                r_pos <= r_pos + 1'b1;
                r_pend <= r_pend + 1'b1;
                r_wptr <= (32'(r_wptr) == Depth - 1) ? '0 : r_wptr + 1'b1;
            end
            if (i_cmd.start_res) r_pend <= r_pend - 1'b1;
            if (i_cmd.clr_frame) begin
                r_pos <= '0;
                r_pend <= '0;
                r_wptr <= '0;
            end
        end
    end

    assign o_sts.over_max = 32'(r_pos) >= MAX_PIXELS;
    assign o_sts.need_res = (r_pend != '0) && (flush || r_pend > reach);
    assign o_sts.taps_done = (r_tap == ntaps - 1'b1);
    assign o_sts.div_done = r_div_busy && (r_dcnt == 0);
    assign o_sts.last_pend = (r_pend == PendW'(1));
endmodule
`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps
module tb;
    localparam int unsigned NPIX = 512;
    localparam int unsigned MAXR = 5;
    localparam int unsigned WDEP = 4 * MAXR + 1;
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;
    localparam logic [1:0] REG_AMOUNT = 2'd3;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       eos;
    } t_px;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_ready;
    logic [7:0] i_pixel_red, i_pixel_green, i_pixel_blue;
    logic       i_end_of_strip;
    logic       o_out_valid;
    logic       i_out_ready;
    logic [7:0] o_out_red, o_out_green, o_out_blue;
    logic       o_frame_done;

    led_strip_blur_blend uut (.*);

    // predictor state
    logic       cf_en;
    logic [1:0] cf_mode;
    logic [2:0] cf_rad;
    logic [7:0] cf_amt;
    logic [23:0] win [WDEP];
    int unsigned pos, pend;

    t_px pix_q[$];
    t_px blur_q[$];
    int  errors;
    int  in_idle, out_idle;
    int  phase;

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report(input string msg);
        $display("MISMATCH @%0t: %s", $time, msg);
        errors++;
    endtask

    function automatic int unsigned eff_rad();
        if (cf_rad == 0) return 1;
        if (cf_rad > MAXR) return MAXR;
        return cf_rad;
    endfunction

    function automatic bit smoothing_on();
        return cf_en && cf_amt != 0;
    endfunction

    function automatic int unsigned blur_reach();
        if (!smoothing_on()) return 0;
        return (cf_mode == 2'd1) ? 2 * eff_rad() : eff_rad();
    endfunction

    function automatic logic [7:0] blend(input int unsigned a, b, m);
        return 8'(((a << 8) + b + b * m - a * m) >> 8);
    endfunction

    function automatic t_px smooth_pixel(input int unsigned e, input logic done);
        logic [23:0] orig, p;
        int unsigned sr, sg, sb, tot, w, rr;
        int          idx;
        t_px         res;
        orig = win[e % WDEP];
        res = {orig, done};
        if (smoothing_on()) begin
            rr = eff_rad();
            sr = 0; sg = 0; sb = 0; tot = 0;
            if (cf_mode == 2'd1) begin
                for (int k = -2; k <= 2; k++) begin
                    idx = int'(e) + k * int'(rr);
                    if (idx >= 0 && idx < int'(pos)) begin
                        p = win[idx % WDEP];
                        w = (k == 0) ? 6 : ((k == 1 || k == -1) ? 4 : 1);
                        sr += p[23:16] * w; sg += p[15:8] * w; sb += p[7:0] * w;
                        tot += w;
                    end
                end
            end else begin
                for (int j = -int'(rr); j <= int'(rr); j++) begin
                    idx = int'(e) + j;
                    if (idx >= 0 && idx < int'(pos)) begin
                        p = win[idx % WDEP];
                        sr += p[23:16]; sg += p[15:8]; sb += p[7:0];
                        tot++;
                    end
                end
            end
            if (tot == 0) tot = 1;
            res.r = blend(orig[23:16], sr / tot, cf_amt);
            res.g = blend(orig[15:8], sg / tot, cf_amt);
            res.b = blend(orig[7:0], sb / tot, cf_amt);
        end
        return res;
    endfunction

    task automatic predict(input t_px x);
        bit flush;
        int unsigned rch;
        if (pos >= NPIX) begin
            blur_q.push_back(x);
        end else begin
            rch = blur_reach();
            win[pos % WDEP] = {x.r, x.g, x.b};
            pos++;
            pend++;
            flush = x.eos || pos >= NPIX;
            while (pend > 0 && (flush || pend > rch)) begin
                blur_q.push_back(smooth_pixel(pos - pend, x.eos && pend == 1));
                pend--;
            end
        end
        if (x.eos) begin
            pos = 0;
            pend = 0;
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 0;
        end else begin
            if (i_in_valid && o_in_ready) predict({i_pixel_red, i_pixel_green,
                                                   i_pixel_blue, i_end_of_strip});
            if (!i_in_valid || o_in_ready) begin
                if (pix_q.size() > 0 && $urandom_range(99) >= in_idle) begin
                    t_px n;
                    n = pix_q.pop_front();
                    i_in_valid <= 1;
                    {i_pixel_red, i_pixel_green, i_pixel_blue, i_end_of_strip} <= n;
                end else begin
                    i_in_valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (blur_q.size() == 0) begin
                    report("unexpected result transaction");
                end else begin
                    t_px e;
                    e = blur_q.pop_front();
                    if (o_out_red !== e.r)
                        report($sformatf("red %0d exp %0d", o_out_red, e.r));
                    if (o_out_green !== e.g)
                        report($sformatf("green %0d exp %0d", o_out_green, e.g));
                    if (o_out_blue !== e.b)
                        report($sformatf("blue %0d exp %0d", o_out_blue, e.b));
                    if (o_frame_done !== e.eos)
                        report($sformatf("frame_done %0b exp %0b", o_frame_done, e.eos));
                end
            end
            i_out_ready <= ($urandom_range(99) >= out_idle);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_ENABLE: cf_en = val[0];
            REG_MODE:   cf_mode = val[1:0];
            REG_RADIUS: cf_rad = val[2:0];
            default:    cf_amt = val;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 0;
    endtask

    task automatic drain();
        while (pix_q.size() > 0 || i_in_valid || blur_q.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic set_all(input logic en, input logic [1:0] md, input logic [2:0] rd,
                           input logic [7:0] am);
        drain();
        write_reg(REG_ENABLE, {7'd0, en});
        write_reg(REG_MODE, {6'd0, md});
        write_reg(REG_RADIUS, {5'd0, rd});
        write_reg(REG_AMOUNT, am);
    endtask

    function automatic t_px rnd_px(input logic eos);
        return {8'($urandom), 8'($urandom), 8'($urandom), eos};
    endfunction

    task automatic queue_strip(input int len);
        for (int i = 0; i < len; i++) pix_q.push_back(rnd_px(i == len - 1));
    endtask

    initial begin
        int n;
        errors = 0;
        in_idle = 34; out_idle = 50;
        cf_en = 1; cf_mode = 0; cf_rad = 1; cf_amt = 255;
        pos = 0; pend = 0;
        for (int i = 0; i < WDEP; i++) win[i] = '0;
        i_rst_n = 0; i_cfg_we = 0; i_cfg_index = '0; i_cfg_data = '0;
        i_in_valid = 0; i_out_ready = 0;
        i_pixel_red = '0; i_pixel_green = '0; i_pixel_blue = '0; i_end_of_strip = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes, single-pixel frame, each mode
        pix_q.push_back({8'hff, 8'h00, 8'hff, 1'b0});
        pix_q.push_back({8'h00, 8'hff, 8'h00, 1'b0});
        pix_q.push_back({8'hff, 8'hff, 8'hff, 1'b0});
        pix_q.push_back({8'h00, 8'h00, 8'h00, 1'b1});
        pix_q.push_back({8'haa, 8'h55, 8'h01, 1'b1});
        set_all(1, 2'd1, 3'd5, 8'd255);
        queue_strip(12);
        set_all(1, 2'd2, 3'd0, 8'd128);
        queue_strip(5);
        set_all(1, 2'd3, 3'd7, 8'd1);
        queue_strip(4);
        set_all(0, 2'd1, 3'd3, 8'd200);
        queue_strip(3);
        set_all(1, 2'd0, 3'd2, 8'd0);
        queue_strip(3);

        for (phase = 0; phase < 3; phase++) begin
            n = 0;
            while (n < 110) begin
                int len;
                set_all($urandom_range(9) != 0, 2'($urandom_range(3)),
                        3'($urandom_range(7)),
                        ($urandom_range(5) == 0) ? 8'd0 :
                        ($urandom_range(5) == 0) ? 8'd255 : 8'($urandom));
                len = $urandom_range(1, 24);
                queue_strip(len);
                n += len;
            end
            drain();
            if (phase == 0) begin
                in_idle = 50; out_idle = 34;
            end else begin
                in_idle = 0; out_idle = 0;
            end
        end

        drain();
        if (errors == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
